// File: hw/rtl/pgd_pkg.sv
`timescale 1ns / 1ps

package pgd_pkg;

   localparam logic       OP_START = 1'b0;
   localparam logic       OP_DATA  = 1'b1;

   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;

   localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd540;
   localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd960;

   localparam logic [15:0] INK_WHITE     = 16'hFFFF;
   localparam logic [15:0] INK_BLACK     = 16'h0000;
   localparam logic [15:0] LEVEL10_BLACK = 16'h294A;
   localparam logic [15:0] LEVEL11_BLACK = 16'h2108;

   localparam logic [2:0] LAST_BIT = 3'd0;
   localparam logic [2:0] FIRST_BIT = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SHIFT = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [15:0] color;
   } pixel_type;

   typedef struct packed {
      logic push;
      logic flush;
   } out_ctrl_type;

   typedef struct packed {
      logic hold_valid;
      logic can_push;
   } out_status_type;

   function automatic logic [15:0] ink_for(input logic [15:0] held, input logic level11);
      logic [15:0] colour;
      if (held == INK_WHITE) begin
         colour = INK_WHITE;
      end else if (held != INK_BLACK) begin
         colour = held;
      end else begin
         colour = level11 ? LEVEL11_BLACK : LEVEL10_BLACK;
      end
      return colour;
   endfunction

endpackage

// File: hw/rtl/prefix_coded_glyph_pixel_decoder_top.sv
`timescale 1ns / 1ps
// Start item: accepted while idle, no result.
// Data byte: a transfer, then up to eight code bits from the byte shift register, each step
// held while a held pixel waits on a stalled result side, then a flush when the byte inked a pixel.
// First pixel of a byte appears once the next inked pixel or the end of the byte is reached.
// Synchronous active-high reset: no active glyph, screen 540 x 960, outputs empty.

module prefix_coded_glyph_pixel_decoder_top
   import pgd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_glyph_w,
   input  logic [7:0]  req_glyph_h,
   input  logic [15:0] req_pen_x,
   input  logic [15:0] req_pen_y,
   input  logic [7:0]  req_x_offset,
   input  logic [7:0]  req_y_offset,
   input  logic [13:0] req_byte_count,
   input  logic [15:0] req_ink_color,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_pixel_x,
   output logic [11:0] rsp_pixel_y,
   output logic [15:0] rsp_pixel_color,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   state_type      state_ff, state_in;
   logic [11:0]    screen_w_ff, screen_w_in;
   logic [11:0]    screen_h_ff, screen_h_in;
   logic [7:0]     cell_w_ff, cell_w_in;
   logic [7:0]     cell_h_ff, cell_h_in;
   logic [15:0]    origin_x_ff, origin_x_in;
   logic [15:0]    pos_x_ff, pos_x_in;
   logic [15:0]    pos_y_ff, pos_y_in;
   logic [7:0]     col_ff, col_in;
   logic [7:0]     row_ff, row_in;
   logic [13:0]    bytes_left_ff, bytes_left_in;
   logic           pending_ff, pending_in;
   logic           done_ff, done_in;
   logic [15:0]    color_ff, color_in;
   logic [7:0]     shift_ff, shift_in;
   logic [2:0]     bit_idx_ff, bit_idx_in;

   out_ctrl_type   out_ctrl;
   out_status_type out_status;
   pixel_type      pixel;

   logic           req_xfer;
   logic           step;
   logic           code_bit;
   logic           in_x, in_y;
   logic           emit;
   logic           advance;
   logic [7:0]     col_inc, row_inc;
   logic           row_wrap;
   logic           done_step;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign step     = (state_ff == ST_SHIFT) && (!out_status.hold_valid || out_status.can_push);
   assign code_bit = shift_ff[7];

   assign in_x = !pos_x_ff[15] && (pos_x_ff[14:12] == 3'd0) && (pos_x_ff[11:0] < screen_w_ff);
   assign in_y = !pos_y_ff[15] && (pos_y_ff[14:12] == 3'd0) && (pos_y_ff[11:0] < screen_h_ff);

   assign emit    = step && pending_ff && in_x && in_y;
   assign advance = step && (pending_ff || !code_bit);

   assign col_inc   = col_ff + 8'd1;
   assign row_inc   = row_ff + 8'd1;
   assign row_wrap  = (col_inc >= cell_w_ff);
   assign done_step = advance && row_wrap && (row_inc >= cell_h_ff);

   assign pixel.x     = pos_x_ff[11:0];
   assign pixel.y     = pos_y_ff[11:0];
   assign pixel.color = ink_for(color_ff, code_bit);

   assign out_ctrl.push  = emit;
   assign out_ctrl.flush = (state_ff == ST_FLUSH) && out_status.can_push;

   always_comb begin
      screen_w_in = screen_w_ff;
      screen_h_in = screen_h_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_w_in = csr_data;
            CSR_SCREEN_HEIGHT: screen_h_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      cell_w_in     = cell_w_ff;
      cell_h_in     = cell_h_ff;
      origin_x_in   = origin_x_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      bytes_left_in = bytes_left_ff;
      pending_in    = pending_ff;
      done_in       = done_ff;
      color_in      = color_ff;
      shift_in      = shift_ff;
      bit_idx_in    = bit_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_op == OP_START) begin
                  cell_w_in     = req_glyph_w;
                  cell_h_in     = req_glyph_h;
                  origin_x_in   = req_pen_x + {{8{req_x_offset[7]}}, req_x_offset};
                  pos_x_in      = req_pen_x + {{8{req_x_offset[7]}}, req_x_offset};
                  pos_y_in      = req_pen_y + {{8{req_y_offset[7]}}, req_y_offset};
                  bytes_left_in = req_byte_count;
                  color_in      = req_ink_color;
                  col_in        = 8'd0;
                  row_in        = 8'd0;
                  pending_in    = 1'b0;
                  done_in       = (req_glyph_w == 8'd0) || (req_glyph_h == 8'd0)
                                  || (req_byte_count == 14'd0);
               end else if (!done_ff && (bytes_left_ff != 14'd0)) begin
                  shift_in      = req_data_byte;
                  bit_idx_in    = FIRST_BIT;
                  bytes_left_in = bytes_left_ff - 14'd1;
                  state_in      = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (step) begin
               shift_in   = {shift_ff[6:0], 1'b0};
               bit_idx_in = bit_idx_ff - 3'd1;
               pending_in = !pending_ff && code_bit;
               if (advance) begin
                  if (row_wrap) begin
                     col_in   = 8'd0;
                     row_in   = row_inc;
                     pos_x_in = origin_x_ff;
                     pos_y_in = pos_y_ff + 16'd1;
                  end else begin
                     col_in   = col_inc;
                     pos_x_in = pos_x_ff + 16'd1;
                  end
               end
               if (done_step) begin
                  done_in = 1'b1;
               end
               if ((bit_idx_ff == LAST_BIT) || done_step) begin
                  // drop a dangling prefix once the byte budget is spent
                  if (bytes_left_ff == 14'd0) begin
                     done_in    = 1'b1;
                     pending_in = 1'b0;
                  end
                  state_in = (out_status.hold_valid || emit) ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (out_status.can_push) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         screen_w_ff   <= SCREEN_WIDTH_RESET;
         screen_h_ff   <= SCREEN_HEIGHT_RESET;
         cell_w_ff     <= 8'd0;
         cell_h_ff     <= 8'd0;
         origin_x_ff   <= 16'd0;
         pos_x_ff      <= 16'd0;
         pos_y_ff      <= 16'd0;
         col_ff        <= 8'd0;
         row_ff        <= 8'd0;
         bytes_left_ff <= 14'd0;
         pending_ff    <= 1'b0;
         done_ff       <= 1'b1;
         color_ff      <= 16'd0;
      end else begin
         state_ff      <= state_in;
         screen_w_ff   <= screen_w_in;
         screen_h_ff   <= screen_h_in;
         cell_w_ff     <= cell_w_in;
         cell_h_ff     <= cell_h_in;
         origin_x_ff   <= origin_x_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         bytes_left_ff <= bytes_left_in;
         pending_ff    <= pending_in;
         done_ff       <= done_in;
         color_ff      <= color_in;
      end
      shift_ff   <= shift_in;
      bit_idx_ff <= bit_idx_in;
   end

   pgd_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (out_ctrl),
      .pixel           (pixel),
      .status          (out_status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

endmodule

// File: hw/rtl/pgd_out_stage.sv
`timescale 1ns / 1ps

module pgd_out_stage
   import pgd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  out_ctrl_type   ctrl,
   input  pixel_type      pixel,
   output out_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [11:0]    rsp_pixel_x,
   output logic [11:0]    rsp_pixel_y,
   output logic [15:0]    rsp_pixel_color,
   output logic           rsp_last
);

   logic      hold_valid_ff, hold_valid_in;
   pixel_type hold_ff, hold_in;
   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_ff, rsp_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      can_push;
   logic      move;

   assign can_push = !rsp_valid_ff || rsp_ready;
   assign move     = hold_valid_ff && (ctrl.push || ctrl.flush);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      // hand the held pixel on; only the flush knows it closes the byte
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_in       = hold_ff;
         rsp_last_in  = ctrl.flush;
      end
      if (ctrl.push) begin
         hold_valid_in = 1'b1;
         hold_in       = pixel;
      end else if (ctrl.flush) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.hold_valid = hold_valid_ff;
   assign status.can_push   = can_push;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_x       = rsp_ff.x;
   assign rsp_pixel_y       = rsp_ff.y;
   assign rsp_pixel_color   = rsp_ff.color;
   assign rsp_last          = rsp_last_ff;

endmodule
